// ===== rtl/core/lvs_pkg.sv =====
package lvs_pkg;

  localparam int SIDE_DEF = 64;
  localparam int FRAC_DEF = 24;

  localparam logic [47:0] E_CAP  = '1;
  localparam logic [15:0] KL_RST = 16'd4096;
  localparam logic [15:0] KT_RST = 16'd1229;
  localparam logic [15:0] DT_RST = 16'd2621;

  localparam logic [3:0] FORCE_LAST  = 4'd8;
  localparam logic [3:0] KD_LAST     = 4'd4;
  localparam logic [3:0] KICK_LAST   = 4'd2;
  localparam logic [3:0] ENERGY_LAST = 4'd7;
  localparam logic [3:0] RD_LAST     = 4'd1;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_WRITE  = 3'd1,
    OP_STEP   = 3'd2,
    OP_READ   = 3'd3,
    OP_ENERGY = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    CFG_KL = 2'd0,
    CFG_KT = 2'd1,
    CFG_DT = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_WR,
    ST_RD,
    ST_FORCE,
    ST_KD,
    ST_KICK,
    ST_ENERGY
  } state_t;

  // x/y displacement pair carried along the cell chain
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } pair_t;

endpackage

// ===== rtl/core/lvs_cell.sv =====
module lvs_cell (
  input  logic           clk,
  input  lvs_pkg::pair_t d_in,
  output lvs_pkg::pair_t d_out
);
  import lvs_pkg::*;

  pair_t q_r;

  always_ff @(posedge clk) begin
    q_r <= d_in;
  end

  assign d_out = q_r;

endmodule

// ===== rtl/core/lattice_verlet_stepper.sv =====
// Ops run one at a time, no back-pressure. Reads and writes first reduce row and col modulo
// SIDE by repeated subtracts; an unused op does no work and just returns a result beat; a step
// runs an extra force pass first when writes left the forces stale.
// Per site, each pass (force, kick-drift, kick, energy) works through its phases with one
// read per memory per cycle, beside a separate write port; displacement taps ride a 5-cell shift chain.
// Reset (sync, rst_n low) loads default registers, then a zeroing sweep of every site, busy high.
module lattice_verlet_stepper #(
  parameter int SIDE      = lvs_pkg::SIDE_DEF,
  parameter int FRAC_BITS = lvs_pkg::FRAC_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_op,
  input  logic [5:0]         in_site_row,
  input  logic [5:0]         in_site_col,
  input  logic signed [31:0] in_new_disp_x,
  input  logic signed [31:0] in_new_disp_y,
  input  logic signed [31:0] in_new_vel_x,
  input  logic signed [31:0] in_new_vel_y,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               out_valid,
  output logic signed [31:0] out_disp_x,
  output logic signed [31:0] out_disp_y,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic [47:0]        out_kinetic_energy,
  output logic [47:0]        out_potential_energy,
  output logic [31:0]        out_steps_done
);
  import lvs_pkg::*;

  localparam int SITES  = SIDE * SIDE;
  localparam int AW     = $clog2(SITES);
  localparam int RW     = $clog2(SIDE);
  localparam int NCELLS = 5;

  // control
  state_t      state_r, state_nxt;
  logic [3:0]  phase_r, phase_nxt;
  logic [RW-1:0] row_r, row_nxt, col_r, col_nxt;
  logic [5:0]  rrow_r, rrow_nxt, rcol_r, rcol_nxt;
  logic [2:0]  op_r;
  logic        fc_r, second_r, emit_r, out_valid_r;
  logic [31:0] steps_r, steps_nxt;
  logic [15:0] kl_r, kt_r, dt_r;
  logic        accept, fin, site_step, pass_done, site_last;

  logic [RW-1:0] rm, rp, cm, cp, rsel, csel;
  logic [AW-1:0] raddr, waddr;

  // memories
  logic [31:0] mem_dx [SITES];
  logic [31:0] mem_dy [SITES];
  logic [31:0] mem_vx [SITES];
  logic [31:0] mem_vy [SITES];
  logic [31:0] mem_fx [SITES];
  logic [31:0] mem_fy [SITES];
  logic signed [31:0] rdx_r, rdy_r, rvx_r, rvy_r, rfx_r, rfy_r;
  logic we_d, we_v, we_f;
  logic [31:0] wd_x, wd_y, wv_x, wv_y, wf_x, wf_y;

  // request payload
  logic signed [31:0] nd_x_r, nd_y_r, nv_x_r, nv_y_r;

  // cell chain
  pair_t chain [NCELLS];
  pair_t chain_in;

  // force pass
  logic signed [33:0] lrx_r, lcx_r, lry_r, lcy_r;
  logic signed [50:0] p1x_r, p2x_r, p1y_r, p2y_r;
  logic signed [51:0] fsx, fsy;

  // kick / drift
  logic signed [16:0] dts;
  logic signed [48:0] kpx_r, kpy_r, kqx, kqy;
  logic signed [31:0] vnx_r, vny_r;
  logic signed [48:0] dpx_r, dpy_r, dqx, dqy;
  logic [31:0] vkx, vky;

  // energy
  logic [32:0] mag_r [4];
  logic [65:0] sq_r [4];
  logic [68:0] hk_r [4];
  logic [28:0] lk_r [4];
  logic [15:0] bk [4];
  logic [32:0] dif [4];
  logic [31:0] mvx_r, mvy_r;
  logic [64:0] vsq_r;
  logic [47:0] ke_r, pe_r, ke_sum, pe_sum, bsat [4];
  logic [69:0] bsum [4];
  logic [50:0] pe_tot;
  logic [65:0] ke_tot;

  // outputs
  logic signed [31:0] o_dx_r, o_dy_r, o_vx_r, o_vy_r;
  logic [47:0] o_ke_r, o_pe_r;
  logic [31:0] o_steps_r;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign site_last = (row_r == RW'(SIDE - 1)) && (col_r == RW'(SIDE - 1));

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r + 4'd1;
    row_nxt   = row_r;
    col_nxt   = col_r;
    rrow_nxt  = rrow_r;
    rcol_nxt  = rcol_r;
    fin       = 1'b0;
    site_step = 1'b0;
    pass_done = 1'b0;
    case (state_r)
      ST_IDLE: begin
        phase_nxt = '0;
        if (start) begin
          row_nxt  = '0;
          col_nxt  = '0;
          rrow_nxt = in_site_row;
          rcol_nxt = in_site_col;
          case (op_t'(in_op))
            OP_CLEAR:  state_nxt = ST_CLEAR;
            OP_WRITE:  state_nxt = ST_MOD;
            OP_READ:   state_nxt = ST_MOD;
            OP_STEP:   state_nxt = fc_r ? ST_KD : ST_FORCE;
            OP_ENERGY: state_nxt = ST_ENERGY;
            default:   fin = 1'b1;
          endcase
        end
      end
      ST_MOD: begin
        phase_nxt = '0;
        // reduce row/col modulo SIDE one subtract per cycle
        if ({3'b000, rrow_r} >= 9'(SIDE)) begin
          rrow_nxt = rrow_r - 6'(SIDE);
        end else if ({3'b000, rcol_r} >= 9'(SIDE)) begin
          rcol_nxt = rcol_r - 6'(SIDE);
        end else begin
          row_nxt   = RW'(rrow_r);
          col_nxt   = RW'(rcol_r);
          state_nxt = (op_r == OP_WRITE) ? ST_WR : ST_RD;
        end
      end
      ST_WR: begin
        fin       = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_RD: begin
        if (phase_r == RD_LAST) begin
          fin       = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_CLEAR:  site_step = 1'b1;
      ST_FORCE:  site_step = (phase_r == FORCE_LAST);
      ST_KD:     site_step = (phase_r == KD_LAST);
      ST_KICK:   site_step = (phase_r == KICK_LAST);
      ST_ENERGY: site_step = (phase_r == ENERGY_LAST);
      default:   state_nxt = ST_IDLE;
    endcase

    if (site_step) begin
      phase_nxt = '0;
      if (col_r == RW'(SIDE - 1)) begin
        col_nxt = '0;
        row_nxt = (row_r == RW'(SIDE - 1)) ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
      if (site_last) begin
        pass_done = 1'b1;
        case (state_r)
          ST_CLEAR: begin
            fin       = emit_r;
            state_nxt = ST_IDLE;
          end
          ST_FORCE: state_nxt = second_r ? ST_KICK : ST_KD;
          ST_KD:    state_nxt = ST_FORCE;
          default: begin
            fin       = 1'b1;
            state_nxt = ST_IDLE;
          end
        endcase
      end
    end
  end

  always_comb begin
    steps_nxt = steps_r;
    if (accept && (in_op == OP_CLEAR)) begin
      steps_nxt = '0;
    end else if (pass_done && (state_r == ST_KICK)) begin
      steps_nxt = steps_r + 32'd1;
    end
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      phase_r     <= '0;
      row_r       <= '0;
      col_r       <= '0;
      rrow_r      <= '0;
      rcol_r      <= '0;
      op_r        <= '0;
      fc_r        <= 1'b1;
      second_r    <= 1'b0;
      emit_r      <= 1'b0;
      out_valid_r <= 1'b0;
      steps_r     <= '0;
      kl_r        <= KL_RST;
      kt_r        <= KT_RST;
      dt_r        <= DT_RST;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      rrow_r      <= rrow_nxt;
      rcol_r      <= rcol_nxt;
      out_valid_r <= fin;
      steps_r     <= steps_nxt;
      if (accept) begin
        op_r     <= in_op;
        emit_r   <= 1'b1;
        second_r <= 1'b0;
        if (in_op == OP_CLEAR) fc_r <= 1'b1;
      end
      if (state_r == ST_WR) fc_r <= 1'b0;
      if (pass_done && (state_r == ST_FORCE)) fc_r <= 1'b1;
      if (pass_done && (state_r == ST_KD)) second_r <= 1'b1;
      if (cfg_valid) begin
        case (cfg_idx_t'(cfg_index))
          CFG_KL:  kl_r <= cfg_data;
          CFG_KT:  kt_r <= cfg_data;
          CFG_DT:  dt_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // ---------------- addressing ----------------
  assign rm = (row_r == '0) ? RW'(SIDE - 1) : row_r - 1'b1;
  assign rp = (row_r == RW'(SIDE - 1)) ? '0 : row_r + 1'b1;
  assign cm = (col_r == '0) ? RW'(SIDE - 1) : col_r - 1'b1;
  assign cp = (col_r == RW'(SIDE - 1)) ? '0 : col_r + 1'b1;

  // taps land in the chain as: cell0 site, cell1 right, cell2 left, cell3 down, cell4 up
  always_comb begin
    rsel = row_r;
    csel = col_r;
    case (state_r)
      ST_FORCE: begin
        case (phase_r)
          4'd0:    rsel = rm;
          4'd1:    rsel = rp;
          4'd2:    csel = cm;
          4'd3:    csel = cp;
          default: ;
        endcase
      end
      ST_ENERGY: begin
        // cell0 site, cell1 right, cell2 down
        case (phase_r)
          4'd0:    rsel = rp;
          4'd1:    csel = cp;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign raddr = AW'(rsel) * AW'(SIDE) + AW'(csel);
  assign waddr = AW'(row_r) * AW'(SIDE) + AW'(col_r);

  // ---------------- write side ----------------
  assign kqx = kpx_r + 49'sd65536;
  assign kqy = kpy_r + 49'sd65536;
  assign vkx = rvx_r + kqx[48:17];
  assign vky = rvy_r + kqy[48:17];
  assign dqx = dpx_r + 49'sd32768;
  assign dqy = dpy_r + 49'sd32768;
  assign fsx = 52'(p1x_r) + 52'(p2x_r) + 52'sd2048;
  assign fsy = 52'(p1y_r) + 52'(p2y_r) + 52'sd2048;

  always_comb begin
    we_d = 1'b0;
    we_v = 1'b0;
    we_f = 1'b0;
    wd_x = '0;
    wd_y = '0;
    wv_x = '0;
    wv_y = '0;
    wf_x = fsx[43:12];
    wf_y = fsy[43:12];
    case (state_r)
      ST_CLEAR: begin
        we_d = 1'b1;
        we_v = 1'b1;
        we_f = 1'b1;
        wf_x = '0;
        wf_y = '0;
      end
      ST_WR: begin
        we_d = 1'b1;
        we_v = 1'b1;
        wd_x = nd_x_r;
        wd_y = nd_y_r;
        wv_x = nv_x_r;
        wv_y = nv_y_r;
      end
      ST_FORCE: we_f = (phase_r == FORCE_LAST);
      ST_KD: begin
        we_d = (phase_r == KD_LAST);
        we_v = (phase_r == KD_LAST);
        wd_x = rdx_r + dqx[47:16];
        wd_y = rdy_r + dqy[47:16];
        wv_x = vnx_r;
        wv_y = vny_r;
      end
      ST_KICK: begin
        we_v = (phase_r == KICK_LAST);
        wv_x = vkx;
        wv_y = vky;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_d) begin
      mem_dx[waddr] <= wd_x;
      mem_dy[waddr] <= wd_y;
    end
    if (we_v) begin
      mem_vx[waddr] <= wv_x;
      mem_vy[waddr] <= wv_y;
    end
    if (we_f) begin
      mem_fx[waddr] <= wf_x;
      mem_fy[waddr] <= wf_y;
    end
    rdx_r <= mem_dx[raddr];
    rdy_r <= mem_dy[raddr];
    rvx_r <= mem_vx[raddr];
    rvy_r <= mem_vy[raddr];
    rfx_r <= mem_fx[raddr];
    rfy_r <= mem_fy[raddr];
  end

  // ---------------- cell chain ----------------
  assign chain_in.x = rdx_r;
  assign chain_in.y = rdy_r;

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    if (i == 0) begin : g_head
      lvs_cell u_cell (.clk(clk), .d_in(chain_in), .d_out(chain[i]));
    end else begin : g_body
      lvs_cell u_cell (.clk(clk), .d_in(chain[i-1]), .d_out(chain[i]));
    end
  end

  // ---------------- energy terms ----------------
  assign bk[0] = kl_r;
  assign bk[1] = kt_r;
  assign bk[2] = kt_r;
  assign bk[3] = kl_r;

  always_comb begin
    dif[0] = 33'($signed(chain[2].x)) - 33'($signed(chain[0].x));
    dif[1] = 33'($signed(chain[2].y)) - 33'($signed(chain[0].y));
    dif[2] = 33'($signed(chain[1].x)) - 33'($signed(chain[0].x));
    dif[3] = 33'($signed(chain[1].y)) - 33'($signed(chain[0].y));
    pe_tot = 51'(pe_r);
    for (int i = 0; i < 4; i++) begin
      bsum[i] = 70'(hk_r[i]) + 70'(lk_r[i][28:13]);
      bsat[i] = (bsum[i] > 70'(E_CAP)) ? E_CAP : bsum[i][47:0];
      pe_tot  = pe_tot + 51'(bsat[i]);
    end
    pe_sum = (pe_tot > 51'(E_CAP)) ? E_CAP : pe_tot[47:0];
    ke_tot = 66'(ke_r) + 66'(vsq_r);
    ke_sum = (ke_tot > 66'(E_CAP)) ? E_CAP : ke_tot[47:0];
  end

  // ---------------- datapath registers ----------------
  assign dts = $signed({1'b0, dt_r});

  always_ff @(posedge clk) begin
    if (accept) begin
      nd_x_r <= in_new_disp_x;
      nd_y_r <= in_new_disp_y;
      nv_x_r <= in_new_vel_x;
      nv_y_r <= in_new_vel_y;
    end

    // force: laps, then products, then round/shift on write
    lrx_r <= 34'(chain[4].x) + 34'(chain[3].x) - $signed({chain[0].x[31], chain[0].x, 1'b0});
    lcx_r <= 34'(chain[2].x) + 34'(chain[1].x) - $signed({chain[0].x[31], chain[0].x, 1'b0});
    lry_r <= 34'(chain[4].y) + 34'(chain[3].y) - $signed({chain[0].y[31], chain[0].y, 1'b0});
    lcy_r <= 34'(chain[2].y) + 34'(chain[1].y) - $signed({chain[0].y[31], chain[0].y, 1'b0});
    p1x_r <= $signed({1'b0, kl_r}) * lrx_r;
    p2x_r <= $signed({1'b0, kt_r}) * lcx_r;
    p1y_r <= $signed({1'b0, kt_r}) * lry_r;
    p2y_r <= $signed({1'b0, kl_r}) * lcy_r;

    // kick and drift
    kpx_r <= dts * rfx_r;
    kpy_r <= dts * rfy_r;
    vnx_r <= vkx;
    vny_r <= vky;
    dpx_r <= dts * vnx_r;
    dpy_r <= dts * vny_r;

    // energy
    for (int i = 0; i < 4; i++) begin
      mag_r[i] <= dif[i][32] ? (~dif[i] + 33'd1) : dif[i];
      sq_r[i]  <= (66'(mag_r[i]) * 66'(mag_r[i])) >> FRAC_BITS;
      hk_r[i]  <= 69'(sq_r[i][65:13]) * 69'(bk[i]);
      lk_r[i]  <= 29'(sq_r[i][12:0]) * 29'(bk[i]);
    end
    mvx_r <= rvx_r[31] ? (~rvx_r + 32'd1) : rvx_r;
    mvy_r <= rvy_r[31] ? (~rvy_r + 32'd1) : rvy_r;
    vsq_r <= (65'(mvx_r) * 65'(mvx_r) + 65'(mvy_r) * 65'(mvy_r)) >> (FRAC_BITS + 1);

    if (accept) begin
      ke_r <= '0;
      pe_r <= '0;
    end else if ((state_r == ST_ENERGY) && (phase_r == ENERGY_LAST)) begin
      ke_r <= ke_sum;
      pe_r <= pe_sum;
    end

    if (fin) begin
      o_dx_r    <= (state_r == ST_RD) ? rdx_r : '0;
      o_dy_r    <= (state_r == ST_RD) ? rdy_r : '0;
      o_vx_r    <= (state_r == ST_RD) ? rvx_r : '0;
      o_vy_r    <= (state_r == ST_RD) ? rvy_r : '0;
      o_ke_r    <= (state_r == ST_ENERGY) ? ke_sum : '0;
      o_pe_r    <= (state_r == ST_ENERGY) ? pe_sum : '0;
      o_steps_r <= steps_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_disp_x           = o_dx_r;
  assign out_disp_y           = o_dy_r;
  assign out_vel_x            = o_vx_r;
  assign out_vel_y            = o_vy_r;
  assign out_kinetic_energy   = o_ke_r;
  assign out_potential_energy = o_pe_r;
  assign out_steps_done       = o_steps_r;

  // ---------------- assertions ----------------
  ap_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while still busy");

  ap_work_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_op <= OP_ENERGY)) |=> busy)
    else $error("accepted op did not start work");

  ap_kick_forces: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_KICK) |-> fc_r)
    else $error("final kick with stale forces");

  ap_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || start))
    else $error("result beat without an item");

endmodule
